// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Each macro places one labeled concurrent assertion that is sampled on the
// rising edge of the given clock and is disabled while the given reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/spb_pkg.sv =====
// ----------------------------------------------------------------------------
// spb_pkg
// Types and constants shared by the sorted priority buffer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spb_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int CMDQ_DEPTH_DEFAULT = 2;
  localparam int RSPQ_DEPTH_DEFAULT = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_ENTRY    = 2'd1,
    KIND_EMPTY    = 2'd2,
    KIND_FULL     = 2'd3
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  priority_req;
    logic [15:0] name_tag;
    logic [31:0] amount_cents;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  out_priority;
    logic [15:0] out_name_tag;
    logic [31:0] out_amount_cents;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic        is_read;
    logic [1:0]  pri;
    logic [15:0] tag;
    logic [31:0] amount;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spb_fifo.sv =====
// ----------------------------------------------------------------------------
// spb_fifo
// Small register-based queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module spb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  output logic             empty,
  input  logic             pop,
  output logic [WIDTH-1:0] dout
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0]   LAST_PTR   = AW'(DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spb_front.sv =====
// ----------------------------------------------------------------------------
// spb_front
// Accepts request items, decodes them into commands and queues them for the
// execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module spb_front #(
  parameter int CMDQ_DEPTH = spb_pkg::CMDQ_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  spb_pkg::req_t req,
  output logic          cmd_valid,
  output spb_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  import spb_pkg::*;

  cmd_t cmd_in;
  logic cmd_empty;

  always_comb begin
    cmd_in.is_read = (req.op == OP_READ);
    cmd_in.pri     = req.priority_req;
    cmd_in.tag     = req.name_tag;
    cmd_in.amount  = req.amount_cents;
  end

  spb_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .din  (cmd_in),
    .empty(cmd_empty),
    .pop  (cmd_pop),
    .dout (cmd)
  );

  assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// ===== hw/rtl/spb_back.sv =====
// ----------------------------------------------------------------------------
// spb_back
// Holds the sorted entry store and carries out insert and read-out commands.
// Inserts compare and shift all slots at once; a read-out rotates the store
// one slot per result so that the front slot is always the one shown.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spb_back #(
  parameter int DEPTH = spb_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  spb_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          res_push,
  input  logic          res_full,
  output spb_pkg::rsp_t res
);

  import spb_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   left;
  logic [CW-1:0]   left_next;
  logic [CW-1:0]   last_idx;
  logic [1:0]      pri_q [DEPTH];
  logic [15:0]     tag_q [DEPTH];
  logic [31:0]     amt_q [DEPTH];
  logic            do_insert;
  logic            do_rotate;
  logic [DEPTH-1:0] above;
  logic [DEPTH-1:0] at_end;
  logic [DEPTH-1:0] above_prev;
  logic [DEPTH-1:0] take_new;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      above[i]  = (CW'(i) < count) && (pri_q[i] > cmd.pri);
      at_end[i] = (CW'(i) == count);
    end
    above_prev = {above[DEPTH-2:0], 1'b0};
    take_new   = (above | at_end) & ~above_prev;
  end

  assign last_idx = count - 1'b1;

  always_comb begin
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res        = '0;
    do_insert  = 1'b0;
    do_rotate  = 1'b0;
    state_next = state;
    count_next = count;
    left_next  = left;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid && !res_full) begin
          res_push = 1'b1;
          res.last = 1'b1;
          if (!cmd.is_read) begin
            cmd_pop = 1'b1;
            if (count == FULL_COUNT) begin
              res.kind = KIND_FULL;
            end else begin
              res.kind   = KIND_ACCEPTED;
              do_insert  = 1'b1;
              count_next = count + 1'b1;
            end
          end else if (count == '0) begin
            cmd_pop  = 1'b1;
            res.kind = KIND_EMPTY;
          end else begin
            res.kind             = KIND_ENTRY;
            res.out_priority     = pri_q[0];
            res.out_name_tag     = tag_q[0];
            res.out_amount_cents = amt_q[0];
            res.last             = (count == ONE_COUNT);
            do_rotate            = 1'b1;
            if (count == ONE_COUNT) begin
              cmd_pop = 1'b1;
            end else begin
              state_next = ST_READ;
              left_next  = count - 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        if (!res_full) begin
          res_push             = 1'b1;
          res.kind             = KIND_ENTRY;
          res.out_priority     = pri_q[0];
          res.out_name_tag     = tag_q[0];
          res.out_amount_cents = amt_q[0];
          res.last             = (left == ONE_COUNT);
          do_rotate            = 1'b1;
          left_next            = left - 1'b1;
          if (left == ONE_COUNT) begin
            cmd_pop    = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      left  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      left  <= left_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_insert) begin
        if (take_new[i]) begin
          pri_q[i] <= cmd.pri;
          tag_q[i] <= cmd.tag;
          amt_q[i] <= cmd.amount;
        end else if (above_prev[i]) begin
          pri_q[i] <= pri_q[AW'((i == 0) ? 0 : i - 1)];
          tag_q[i] <= tag_q[AW'((i == 0) ? 0 : i - 1)];
          amt_q[i] <= amt_q[AW'((i == 0) ? 0 : i - 1)];
        end
      end else if (do_rotate) begin
        if (CW'(i) == last_idx) begin
          pri_q[i] <= pri_q[0];
          tag_q[i] <= tag_q[0];
          amt_q[i] <= amt_q[0];
        end else if (CW'(i) < last_idx) begin
          pri_q[i] <= pri_q[AW'((i == DEPTH - 1) ? i : i + 1)];
          tag_q[i] <= tag_q[AW'((i == DEPTH - 1) ? i : i + 1)];
          amt_q[i] <= amt_q[AW'((i == DEPTH - 1) ? i : i + 1)];
        end
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= FULL_COUNT, "Entry count is above the depth.")
  `ASSERT_NEXT(a_reject_keeps_count, clk, rst, state == ST_IDLE && cmd_valid && !res_full && !cmd.is_read && count == FULL_COUNT, count == FULL_COUNT, "A rejected insert changed the count.")
  `ASSERT_IMPL(a_read_left, clk, rst, state == ST_READ, left != '0 && left < count, "Read-out counter is out of range.")
  `ASSERT_IMPL(a_pop_with_result, clk, rst, cmd_pop, res_push && res.last, "A command retired without its last result.")

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_priority_buffer.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_buffer
// Bounded buffer of entries kept in ascending priority order, with insert and
// full read-out commands.
//
//   Channel   Handshake          Payload  Accepted when
//   request   push / full        req      push && !full
//   result    empty / pop        rsp      pop && !empty
//
// An insert is carried out in the execution unit and gives one result.
// A read-out gives one result per stored entry, one per cycle unless the result
// queue is full, or one result if the store is empty; store rotation sets the pace.
// Synchronous reset empties the store and both queues; no clearing pass.
// Requests are queued ahead of the execution unit and results behind it, so
// a stalled result side only stops requests once the request queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_buffer #(
  parameter int DEPTH      = spb_pkg::DEPTH_DEFAULT,
  parameter int CMDQ_DEPTH = spb_pkg::CMDQ_DEPTH_DEFAULT,
  parameter int RSPQ_DEPTH = spb_pkg::RSPQ_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  spb_pkg::req_t req,
  output logic          empty,
  input  logic          pop,
  output spb_pkg::rsp_t rsp
);

  import spb_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_push;
  logic res_full;
  rsp_t res;

  spb_front #(
    .CMDQ_DEPTH(CMDQ_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req      (req),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  spb_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res_full (res_full),
    .res      (res)
  );

  spb_fifo #(
    .WIDTH($bits(rsp_t)),
    .DEPTH(RSPQ_DEPTH)
  ) u_rspq (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .full (res_full),
    .din  (res),
    .empty(empty),
    .pop  (pop),
    .dout (rsp)
  );

endmodule

`default_nettype wire

// ===== tb/spb_order_checker.sv =====
// ----------------------------------------------------------------------------
// spb_order_checker
// Watches both queue sides of the sorted priority buffer. It keeps its own
// copy of the ordered store, works out the results of every accepted request
// and compares every accepted result, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module spb_order_checker #(
  parameter int DEPTH = spb_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic          full,
  input  spb_pkg::req_t req,
  input  logic          empty,
  input  logic          pop,
  input  spb_pkg::rsp_t rsp,
  output int            pending,
  output int            fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import spb_pkg::*;

  logic [1:0]  slot_pri [DEPTH];
  logic [15:0] slot_tag [DEPTH];
  logic [31:0] slot_amt [DEPTH];
  int          stored = 0;
  int          errs = 0;
  rsp_t        expected_rsp [$];

  task automatic apply_request(input req_t r);
    rsp_t e;
    int   pos;
    bit   found;
    e = '0;
    e.last = 1'b1;
    if (r.op == OP_INSERT) begin
      if (stored >= DEPTH) begin
        e.kind = KIND_FULL;
      end else begin
        pos = stored;
        found = 1'b0;
        for (int i = 0; i < stored; i++) begin
          if (!found && slot_pri[i] > r.priority_req) begin
            pos = i;
            found = 1'b1;
          end
        end
        for (int i = stored; i > pos; i--) begin
          slot_pri[i] = slot_pri[i-1];
          slot_tag[i] = slot_tag[i-1];
          slot_amt[i] = slot_amt[i-1];
        end
        slot_pri[pos] = r.priority_req;
        slot_tag[pos] = r.name_tag;
        slot_amt[pos] = r.amount_cents;
        stored++;
        e.kind = KIND_ACCEPTED;
      end
      expected_rsp.push_back(e);
    end else if (stored == 0) begin
      e.kind = KIND_EMPTY;
      expected_rsp.push_back(e);
    end else begin
      for (int i = 0; i < stored; i++) begin
        e.kind             = KIND_ENTRY;
        e.out_priority     = slot_pri[i];
        e.out_name_tag     = slot_tag[i];
        e.out_amount_cents = slot_amt[i];
        e.last             = (i == stored - 1);
        expected_rsp.push_back(e);
      end
    end
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t e;
    if (expected_rsp.size() == 0) begin
      $error("result with nothing expected: kind %0d", got.kind);
      errs++;
    end else begin
      e = expected_rsp.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, got.kind);
        errs++;
      end
      if (got.out_priority !== e.out_priority) begin
        $error("out_priority: expected %0d, actual %0d", e.out_priority, got.out_priority);
        errs++;
      end
      if (got.out_name_tag !== e.out_name_tag) begin
        $error("out_name_tag: expected 0x%0h, actual 0x%0h", e.out_name_tag,
               got.out_name_tag);
        errs++;
      end
      if (got.out_amount_cents !== e.out_amount_cents) begin
        $error("out_amount_cents: expected 0x%0h, actual 0x%0h", e.out_amount_cents,
               got.out_amount_cents);
        errs++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, got.last);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) apply_request(req);
      if (pop && !empty) check_result(rsp);
    end
    pending    <= expected_rsp.size();
    fail_count <= errs;
  end

endmodule

// ===== tb/tb_sorted_priority_buffer.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_priority_buffer
// Drives insert and read-out items into the sorted priority buffer under
// several idle and stall patterns, including a long result hold-off that
// backs up the request side, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_sorted_priority_buffer;
  timeunit 1ns;
  timeprecision 1ps;

  import spb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  req_t req = '0;
  logic empty;
  logic pop = 1'b0;
  rsp_t rsp;
  int   pending;
  int   fail_count;

  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic hold_go = 1'b0;
  int   hold_left = 0;

  always #5 clk = ~clk;

  sorted_priority_buffer i_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .req   (req),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
  );

  spb_order_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req        (req),
    .empty      (empty),
    .pop        (pop),
    .rsp        (rsp),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // The long hold-off is counted here, apart from the sender.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      hold_left <= 0;
    end else if (hold_go) begin
      pop <= 1'b0;
      hold_left <= 300;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic req_t make_req(op_t op, logic [1:0] pri, logic [15:0] tag,
                                    logic [31:0] amt);
    req_t r;
    r.op           = op;
    r.priority_req = pri;
    r.name_tag     = tag;
    r.amount_cents = amt;
    return r;
  endfunction

  task automatic send_item(input req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req  <= r;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int idle_pct [4];
    int stall_pct [4];
    idle_pct  = '{0, 54, 0, 34};
    stall_pct = '{0, 0, 54, 34};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty read-out, extremes of every field, ties at both ends.
    send_item(make_req(OP_READ, 2'd3, 16'hffff, 32'hffff_ffff));
    send_item(make_req(OP_INSERT, 2'd3, 16'hffff, 32'hffff_ffff));
    send_item(make_req(OP_INSERT, 2'd0, 16'h0000, 32'h0000_0000));
    send_item(make_req(OP_INSERT, 2'd2, 16'h5a5a, 32'h8000_0001));
    send_item(make_req(OP_INSERT, 2'd0, 16'ha5a5, 32'h7fff_fffe));
    send_item(make_req(OP_INSERT, 2'd1, 16'h0001, 32'h0000_0064));
    send_item(make_req(OP_INSERT, 2'd3, 16'h8000, 32'h1234_5678));
    send_item(make_req(OP_READ, 2'd0, 16'h0000, 32'h0000_0000));

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct = idle_pct[ph];
      rx_stall_pct <= stall_pct[ph];
      if (ph == 0) begin
        push    <= 1'b0;
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      for (int n = 0; n < 106; n++) begin
        send_item(make_req(($urandom_range(3) == 0) ? OP_INSERT : OP_READ,
                           2'($urandom_range(3)), 16'($urandom), $urandom));
      end
    end
    push <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
